### rtl/tcw_pkg.sv
// Package for the text console writer: shared constants, command codes,
// FSM state type and the controller/datapath interface structs.
// No dependencies.
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int IN_DW    = 24;   // char_code, read_row, read_col padded to bytes
  localparam int OUT_DW   = 32;   // cursor_col, cursor_row, cell_char, cell_attr
  localparam int CFG_IDX_W = 1;

  localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'h1F;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h07;
  localparam logic [CHAR_W-1:0] SPACE_CHAR     = 8'h20;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'd1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCR_RD,
    ST_SCR_CPY,
    ST_BLANK,
    ST_RESP
  } tcw_state_t;

  typedef struct packed {
    logic ld_in;       // latch the accepted beat
    logic rd_in;       // read cell addressed by the input beat
    logic rd_scr;      // read source cell of the scroll copy
    logic cnt_clr;
    logic cnt_inc;
    logic wr_put;      // write character at cursor
    logic wr_copy;     // write read data at sweep counter
    logic wr_blank;    // write blank at sweep counter
    logic blank_init;  // blank uses the reset attribute
    logic cur_adv;
    logic cur_home;
    logic out_load;
  } tcw_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             wrap_last;  // cursor on last column of last row
    logic             copy_last;  // final scroll copy address
    logic             cnt_last;   // sweep at last cell
    logic             out_free;
  } tcw_stat_t;

endpackage

### rtl/tcw_ctrl.sv
// Controller FSM for the text console writer: sequences reset clearing,
// put, clear, read and the scroll copy. Depends on tcw_pkg.
module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tcw_stat_t stat,
  output tcw_ctl_t  ctl
);

  tcw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (stat.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.cmd == CMD_PUT && stat.wrap_last) begin
          state_nxt = ST_SCR_RD;
        end else if (stat.cmd == CMD_CLEAR) begin
          state_nxt = ST_BLANK;
        end else if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_SCR_RD:  state_nxt = ST_SCR_CPY;
      ST_SCR_CPY: begin
        if (stat.copy_last) state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        if (stat.cnt_last) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_INIT: begin
        ctl.wr_blank   = 1'b1;
        ctl.blank_init = 1'b1;
        ctl.cnt_inc    = 1'b1;
        ctl.cnt_clr    = stat.cnt_last;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        ctl.ld_in = in_tvalid;
        ctl.rd_in = in_tvalid;
      end
      ST_EXEC: begin
        if (stat.cmd == CMD_PUT) begin
          ctl.wr_put  = 1'b1;
          ctl.cur_adv = 1'b1;
        end
        if (stat.cmd == CMD_CLEAR) begin
          ctl.cur_home = 1'b1;
          ctl.cnt_clr  = 1'b1;
        end else if (stat.cmd == CMD_PUT && stat.wrap_last) begin
          ctl.cnt_clr = 1'b1;
        end else begin
          ctl.out_load = stat.out_free;
        end
      end
      ST_SCR_RD: begin
        ctl.rd_scr = 1'b1;
      end
      ST_SCR_CPY: begin
        ctl.wr_copy = 1'b1;
        ctl.cnt_inc = 1'b1;
        ctl.rd_scr  = !stat.copy_last;
      end
      ST_BLANK: begin
        ctl.wr_blank = 1'b1;
        ctl.cnt_inc  = 1'b1;
        ctl.cnt_clr  = stat.cnt_last;
      end
      ST_RESP: begin
        ctl.out_load = stat.out_free;
      end
      default: ctl = '0;
    endcase
  end

endmodule

### rtl/tcw_datapath.sv
// Datapath for the text console writer: screen buffer memory, cursor,
// sweep counter, config registers and output register. Depends on tcw_pkg.
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcw_ctl_t             ctl,
  output tcw_stat_t            stat,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [CHAR_W-1:0]    in_char,
  input  logic [ROW_W-1:0]     in_row,
  input  logic [COL_W-1:0]     in_col,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ATTR_W-1:0]    cfg_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_DW-1:0]    out_tdata
);

  localparam int N      = COLS * ROWS;
  localparam int ADDR_W = $clog2(N);

  logic [CELL_W-1:0] mem [N];
  logic [CELL_W-1:0] rdata_r;

  logic [ATTR_W-1:0] text_attr_r, blank_attr_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [CHAR_W-1:0] char_r;
  logic              hit_r;
  logic [COL_W-1:0]  cur_x_r, cur_x_nxt;
  logic [ROW_W-1:0]  cur_y_r, cur_y_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;

  logic              in_hit;
  logic [ADDR_W-1:0] cur_pos, in_pos, scr_pos, waddr, raddr;
  logic [CELL_W-1:0] wdata;
  logic              we, re;
  logic [ATTR_W-1:0] blank_attr;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r  <= TEXT_ATTR_RST;
      blank_attr_r <= BLANK_ATTR_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TEXT_ATTR)  text_attr_r  <= cfg_data;
      if (cfg_index == REG_BLANK_ATTR) blank_attr_r <= cfg_data;
    end
  end

  assign in_hit = (in_cmd == CMD_READ) &&
                  ({1'b0, in_row} < (ROW_W + 1)'(ROWS)) &&
                  ({1'b0, in_col} < (COL_W + 1)'(COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CMD_READ;
      hit_r <= 1'b0;
    end else if (ctl.ld_in) begin
      cmd_r <= in_cmd;
      hit_r <= in_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_in) char_r <= in_char;
  end

  // cursor: home on clear; advance wraps to next row, stays on last row (scroll follows)
  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (ctl.cur_home) begin
      cur_x_nxt = '0;
      cur_y_nxt = '0;
    end else if (ctl.cur_adv) begin
      if ({1'b0, cur_x_r} + 8'd1 < (COL_W + 1)'(COLS)) begin
        cur_x_nxt = cur_x_r + 1'b1;
      end else begin
        cur_x_nxt = '0;
        if ({1'b0, cur_y_r} + 6'd1 < (ROW_W + 1)'(ROWS)) cur_y_nxt = cur_y_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.cnt_clr)      cnt_nxt = '0;
    else if (ctl.cnt_inc) cnt_nxt = cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  assign cur_pos = ADDR_W'(cur_y_r) * ADDR_W'(COLS) + ADDR_W'(cur_x_r);
  assign in_pos  = ADDR_W'(in_row) * ADDR_W'(COLS) + ADDR_W'(in_col);
  // source of the copy runs one row ahead; prefetch next while copying
  assign scr_pos = cnt_r + ADDR_W'(COLS) + ADDR_W'(ctl.cnt_inc);

  assign blank_attr = ctl.blank_init ? BLANK_ATTR_RST : blank_attr_r;

  always_comb begin
    we    = ctl.wr_put | ctl.wr_copy | ctl.wr_blank;
    waddr = cnt_r;
    wdata = {blank_attr, SPACE_CHAR};
    if (ctl.wr_put) begin
      waddr = cur_pos;
      wdata = {text_attr_r, char_r};
    end else if (ctl.wr_copy) begin
      wdata = rdata_r;
    end
  end

  assign re    = (ctl.rd_in && in_hit) || ctl.rd_scr;
  assign raddr = ctl.rd_scr ? scr_pos : in_pos;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign cell_char = (cmd_r == CMD_READ && hit_r) ? rdata_r[CHAR_W-1:0] : '0;
  assign cell_attr = (cmd_r == CMD_READ && hit_r) ? rdata_r[CELL_W-1:CHAR_W] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r <= {4'd0, cell_attr, cell_char, cur_y_nxt, cur_x_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign stat.cmd       = cmd_r;
  assign stat.wrap_last = (cur_x_r == COL_W'(COLS - 1)) && (cur_y_r == ROW_W'(ROWS - 1));
  assign stat.copy_last = (cnt_r == ADDR_W'(N - COLS - 1));
  assign stat.cnt_last  = (cnt_r == ADDR_W'(N - 1));
  assign stat.out_free  = !out_valid_r || out_tready;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_x_r} < (COL_W + 1)'(COLS)) && ({1'b0, cur_y_r} < (ROW_W + 1)'(ROWS)))
    else $error("cursor outside screen");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.wr_put, ctl.wr_copy, ctl.wr_blank}))
    else $error("conflicting memory writes");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} < (ADDR_W + 1)'(N))
    else $error("sweep counter beyond screen");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwrites pending beat");

  a_copy_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_copy |-> $past(ctl.rd_scr))
    else $error("scroll copy without source read");

endmodule

### rtl/text_console_writer_top.sv
// Put and read load the result in ST_EXEC, or in ST_RESP when the output is full or a put scrolls;
// a result waits in an output register, and the next beat is accepted once the current one is done.
// Clear blanks every cell in ST_BLANK; a put that scrolls copies rows up (ST_SCR_RD, ST_SCR_CPY)
// and then blanks the last row, sweeping the screen memory one cell per cycle.
// Reset (rst_n, synchronous, active low) starts a clearing pass in ST_INIT
// that blanks the screen; no input beat is accepted until it ends.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [CMD_W-1:0]     in_tuser,   // command
  input  logic [IN_DW-1:0]     in_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_DW-1:0]    out_tdata,  // cursor_col[6:0], cursor_row[11:7],
                                           // cell_char[19:12], cell_attr[27:20]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ATTR_W-1:0]    cfg_data
);

  tcw_ctl_t  ctl;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_cmd     (in_tuser),
    .in_char    (in_tdata[7:0]),
    .in_row     (in_tdata[12:8]),
    .in_col     (in_tdata[19:13]),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### dv/tb_top.sv
// Testbench for text_console_writer_top: directed cell reads and writes, a screen fill
// with puts, a long receiver hold-off, then random put/read/clear traffic that scrolls
// under idling and stalls. Depends on rtl/tcw_pkg.sv and rtl/text_console_writer_top.sv.
module tb_top;
  import tcw_pkg::*;

  localparam int SCREEN_COLS = COLS_DEF;
  localparam int SCREEN_ROWS = ROWS_DEF;
  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // cursor and cell as one out_tdata beat carries them, lowest field last
  typedef struct packed {
    logic [ATTR_W-1:0] cell_attr;
    logic [CHAR_W-1:0] cell_char;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } console_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [CMD_W-1:0]     in_tuser = CMD_PUT;
  logic [IN_DW-1:0]     in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_DW-1:0]    out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TEXT_ATTR;
  logic [ATTR_W-1:0]    cfg_data = '0;

  // predicted console state
  logic [CELL_W-1:0] screen_mem [0:CELLS-1];
  int                cur_x = 0;
  int                cur_y = 0;
  logic [ATTR_W-1:0] text_attr_m = TEXT_ATTR_RST;
  logic [ATTR_W-1:0] blank_attr_m = BLANK_ATTR_RST;
  console_report_t   cursor_reports [$];

  int mismatches = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int hold_left = 0;

  always #6 clk = ~clk;

  text_console_writer_top #(
    .COLS(SCREEN_COLS),
    .ROWS(SCREEN_ROWS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  task automatic blank_cells(input int first, input int count);
    for (int i = first; i < first + count && i < CELLS; i++)
      screen_mem[CELL_AW'(i)] = {blank_attr_m, SPACE_CHAR};
  endtask

  // advance the predicted console by one command and queue the report it gives
  task automatic console_apply(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                               input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    console_report_t rep;
    rep = '0;
    case (cmd)
      CMD_PUT: begin
        screen_mem[CELL_AW'(cur_y * SCREEN_COLS + cur_x)] = {text_attr_m, ch};
        if (cur_x + 1 < SCREEN_COLS) begin
          cur_x++;
        end else begin
          cur_x = 0;
          if (cur_y + 1 >= SCREEN_ROWS) begin
            for (int i = 0; i + SCREEN_COLS < CELLS; i++)
              screen_mem[CELL_AW'(i)] = screen_mem[CELL_AW'(i + SCREEN_COLS)];
            blank_cells((SCREEN_ROWS - 1) * SCREEN_COLS, SCREEN_COLS);
          end else begin
            cur_y++;
          end
        end
      end
      CMD_CLEAR: begin
        cur_x = 0;
        cur_y = 0;
        blank_cells(0, CELLS);
      end
      CMD_READ: begin
        if (int'(row) < SCREEN_ROWS && int'(col) < SCREEN_COLS)
          {rep.cell_attr, rep.cell_char} =
            screen_mem[CELL_AW'(int'(row) * SCREEN_COLS + int'(col))];
      end
      default: ;
    endcase
    rep.cursor_col = cur_x[COL_W-1:0];
    rep.cursor_row = cur_y[ROW_W-1:0];
    cursor_reports.push_back(rep);
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                          input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, col, row, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    console_apply(cmd, ch, row, col);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (cursor_reports.size() != 0) @(posedge clk);
  endtask

  // both attribute registers, written only with nothing in flight
  task automatic set_attrs(input logic [ATTR_W-1:0] text_val, input logic [ATTR_W-1:0] blank_val);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? REG_TEXT_ATTR : REG_BLANK_ATTR;
      cfg_data  <= (i == 0) ? text_val : blank_val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i == 0) text_attr_m = text_val;
      else blank_attr_m = blank_val;
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly puts with random bytes; reads pick an on-screen cell three times in four
  task automatic random_traffic(input int count, input int clear_pct);
    int pick;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(3) != 0) begin
        row = ROW_W'($urandom_range(SCREEN_ROWS - 1));
        col = COL_W'($urandom_range(SCREEN_COLS - 1));
      end else begin
        row = ROW_W'($urandom_range(31));
        col = COL_W'($urandom_range(127));
      end
      if (pick < clear_pct)
        send_cmd(CMD_CLEAR, CHAR_W'($urandom_range(255)), row, col);
      else if (pick < clear_pct + 15)
        send_cmd(CMD_READ, CHAR_W'($urandom_range(255)), row, col);
      else if (pick < clear_pct + 17)
        send_cmd(CMD_UNUSED, CHAR_W'($urandom_range(255)), row, col);
      else
        send_cmd(CMD_PUT, CHAR_W'($urandom_range(255)), row, col);
    end
    wait_drained();
  endtask

  task automatic test_directed_cells();
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
    send_cmd(CMD_READ, 8'h00, ROW_W'(SCREEN_ROWS - 1), COL_W'(SCREEN_COLS - 1));
    send_cmd(CMD_READ, 8'h00, ROW_W'(SCREEN_ROWS), 7'd0);   // row just off screen
    send_cmd(CMD_READ, 8'h00, 5'd0, COL_W'(SCREEN_COLS));   // column just off screen
    send_cmd(CMD_READ, 8'hFF, 5'd31, 7'd127);
    send_cmd(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);
    send_cmd(CMD_PUT, 8'h00, 5'd31, 7'd127);
    send_cmd(CMD_PUT, 8'hFF, 5'd0, 7'd0);
    send_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
    send_cmd(CMD_READ, 8'h00, 5'd0, 7'd1);
    send_cmd(CMD_READ, 8'h00, 5'd0, 7'd2);
    send_cmd(CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
    send_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
    send_cmd(CMD_PUT, 8'h41, 5'd0, 7'd0);
    send_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
    wait_drained();
  endtask

  // one screen of puts always passes the last cell, so it scrolls once and
  // leaves the cursor on the bottom row for the traffic that follows
  task automatic test_fill_and_scroll();
    set_attrs(8'h00, 8'hFF);
    in_idle_pct = 0;
    out_stall_pct = 0;
    for (int n = 0; n < CELLS; n++)
      send_cmd(CMD_PUT, CHAR_W'($urandom_range(255)), ROW_W'($urandom_range(31)),
               COL_W'($urandom_range(127)));
    wait_drained();
  endtask

  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    holdoff_req <= holdoff_req + 1;
    for (int n = 0; n < 24; n++)
      send_cmd(CMD_PUT, CHAR_W'($urandom_range(255)), ROW_W'($urandom_range(31)),
               COL_W'($urandom_range(127)));
    wait_drained();
  endtask

  task automatic test_sender_gaps();
    set_attrs(8'hFF, 8'h00);
    in_idle_pct = 81;
    out_stall_pct = 0;
    random_traffic(100, 0);
  endtask

  task automatic test_receiver_stalls();
    set_attrs(ATTR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)));
    in_idle_pct = 0;
    out_stall_pct = 81;
    random_traffic(100, 0);
  endtask

  task automatic test_mixed_idle();
    set_attrs(TEXT_ATTR_RST, BLANK_ATTR_RST);
    in_idle_pct = 34;
    out_stall_pct = 34;
    random_traffic(100, 2);
  endtask

  // receiver side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      hold_left    <= HOLDOFF_CYCLES;
      out_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    console_report_t want;
    console_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(console_report_t)-1:0];
      if (cursor_reports.size() == 0) begin
        $error("result beat with no command outstanding: %h", out_tdata);
        mismatches++;
      end else begin
        want = cursor_reports.pop_front();
        if (got.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
          mismatches++;
        end
        if (got.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
          mismatches++;
        end
        if (got.cell_char !== want.cell_char) begin
          $error("cell_char: expected %0h, got %0h", want.cell_char, got.cell_char);
          mismatches++;
        end
        if (got.cell_attr !== want.cell_attr) begin
          $error("cell_attr: expected %0h, got %0h", want.cell_attr, got.cell_attr);
          mismatches++;
        end
      end
    end
  end

  // ends the run if no beat moves on any channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    blank_cells(0, CELLS);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cells();
    test_fill_and_scroll();
    test_backpressure();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && cursor_reports.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
